/* sv/rudp_pkg.sv */
`default_nettype none
package rudp_pkg;

  localparam int HISTORY_SLOTS_DEF = 32;
  localparam int WINDOW            = 32;

  localparam logic [1:0] REQ_SEND_UNREL = 2'd0;
  localparam logic [1:0] REQ_SEND_REL   = 2'd1;
  localparam logic [1:0] REQ_RECEIVE    = 2'd2;

  localparam logic [1:0] KIND_SEND_STAMP = 2'd0;
  localparam logic [1:0] KIND_RESEND     = 2'd1;
  localparam logic [1:0] KIND_RX_DONE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK
  } rudp_state_t;

endpackage
`default_nettype wire

/* sv/rudp_ram.sv */
`default_nettype none
module rudp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/reliable_udp_ack_tracker_top.sv */
`default_nettype none
// Sequence/ack-bitfield reliability endpoint. Assert start with a request while
// busy is low; the request is taken on that edge. Every result appears for a
// single cycle with out_valid high and must be captured then, since the block
// cannot be held off; out_last marks the final result of a request. An
// unreliable send returns its stamp in the cycle after the transfer. A reliable
// send scans the slot valid bits one per cycle for the lowest free slot and
// reports a full history if none is free. A receive walks the history one slot
// per cycle through the slot sequence RAM (registered read), counting drops in
// the same pass. Any resend orders are issued one per cycle during the walk.
// Request code 3 is accepted and ignored.
module reliable_udp_ack_tracker_top
  import rudp_pkg::*;
#(
  parameter int HISTORY_SLOTS = HISTORY_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_rx_sequence,
  input  wire logic [31:0] in_rx_ack,
  input  wire logic [31:0] in_rx_ack_bits,
  output logic             out_valid,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_sequence,
  output logic [31:0]      out_ack,
  output logic [31:0]      out_ack_bits,
  output logic [4:0]       out_slot_index,
  output logic             out_history_full,
  output logic [5:0]       out_dropped_count,
  output logic [5:0]       out_window_count,
  output logic             out_last
);

  localparam int SLOT_W   = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int WALK_LEN = (HISTORY_SLOTS > WINDOW) ? HISTORY_SLOTS : WINDOW;
  localparam int CNT_W    = $clog2(WALK_LEN + 1);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(HISTORY_SLOTS);
  localparam logic [CNT_W-1:0] WALK_C   = CNT_W'(WALK_LEN);
  localparam logic [CNT_W-1:0] WINDOW_C = CNT_W'(WINDOW);

  rudp_state_t state_r, state_nxt;

  logic [31:0]              local_seq_r,  local_seq_nxt;
  logic [31:0]              remote_seq_r, remote_seq_nxt;
  logic [31:0]              ack_bits_r,   ack_bits_nxt;
  logic [HISTORY_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]         cnt_r,        cnt_nxt;
  logic                     pipe_vld_r,   pipe_vld_nxt;
  logic [SLOT_W-1:0]        pipe_idx_r,   pipe_idx_nxt;
  logic [31:0]              next_seq_r,   next_seq_nxt;
  logic [31:0]              rack_r,       rack_nxt;
  logic [31:0]              rbits_r,      rbits_nxt;
  logic [5:0]               window_r,     window_nxt;
  logic [5:0]               dropped_r,    dropped_nxt;

  logic        out_valid_r,   out_valid_nxt;
  logic [1:0]  out_kind_r,    out_kind_nxt;
  logic [31:0] out_seq_r,     out_seq_nxt;
  logic [31:0] out_ack_r,     out_ack_nxt;
  logic [31:0] out_bits_r,    out_bits_nxt;
  logic [4:0]  out_slot_r,    out_slot_nxt;
  logic        out_full_r,    out_full_nxt;
  logic [5:0]  out_drop_r,    out_drop_nxt;
  logic [5:0]  out_win_r,     out_win_nxt;
  logic        out_last_r,    out_last_nxt;

  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic [31:0]       ram_wr_data;
  logic              ram_rd_en;
  logic [31:0]       ram_rd_data;

  logic              accept;
  logic [31:0]       rx_diff;
  logic              rx_newer;
  logic [31:0]       ack_delta;
  logic              too_old;
  logic              acked;
  logic [SLOT_W-1:0] cnt_slot;

  assign accept    = start && (state_r == ST_IDLE);
  assign rx_diff   = in_rx_sequence - remote_seq_r;
  assign rx_newer  = (rx_diff != 32'd0) && !rx_diff[31];
  assign cnt_slot  = cnt_r[SLOT_W-1:0];

  // history slot under evaluation, data from the RAM read issued last cycle
  assign ack_delta = rack_r - ram_rd_data;
  assign too_old   = (rack_r >= 32'(WINDOW)) && ((rack_r - 32'(WINDOW)) >= ram_rd_data);
  assign acked     = (ack_delta < 32'(WINDOW)) && rbits_r[ack_delta[4:0]];

  rudp_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_SLOTS),
    .ADDR_W(SLOT_W)
  ) u_slot_seq (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(cnt_slot),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_SEND_REL) begin
            state_nxt = ST_SEARCH;
          end else if (in_req_type == REQ_RECEIVE) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_SEARCH: begin
        if (!slot_valid_r[cnt_slot] || (cnt_r == SLOTS_C - CNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if ((cnt_r == WALK_C) && !pipe_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    local_seq_nxt  = local_seq_r;
    remote_seq_nxt = remote_seq_r;
    ack_bits_nxt   = ack_bits_r;
    slot_valid_nxt = slot_valid_r;
    cnt_nxt        = cnt_r;
    pipe_vld_nxt   = 1'b0;
    pipe_idx_nxt   = pipe_idx_r;
    next_seq_nxt   = next_seq_r;
    rack_nxt       = rack_r;
    rbits_nxt      = rbits_r;
    window_nxt     = window_r;
    dropped_nxt    = dropped_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt_slot;
    ram_wr_data = local_seq_r;
    ram_rd_en   = 1'b0;

    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_SEND_STAMP;
    out_seq_nxt   = local_seq_r;
    out_ack_nxt   = remote_seq_r;
    out_bits_nxt  = ack_bits_r;
    out_slot_nxt  = 5'd0;
    out_full_nxt  = 1'b0;
    out_drop_nxt  = 6'd0;
    out_win_nxt   = 6'd0;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt     = '0;
        dropped_nxt = 6'd0;
        if (accept) begin
          unique case (in_req_type)
            REQ_SEND_UNREL: begin
              local_seq_nxt = local_seq_r + 32'd1;
              out_valid_nxt = 1'b1;
              out_seq_nxt   = local_seq_r + 32'd1;
            end
            REQ_SEND_REL: begin
              local_seq_nxt = local_seq_r + 32'd1;
            end
            REQ_RECEIVE: begin
              rack_nxt     = in_rx_ack;
              rbits_nxt    = in_rx_ack_bits;
              next_seq_nxt = local_seq_r;
              window_nxt   = 6'd0;
              if (rx_newer) begin
                remote_seq_nxt = in_rx_sequence;
                ack_bits_nxt   = ((rx_diff >= 32'(WINDOW)) ? 32'd0
                                  : (ack_bits_r << rx_diff[4:0])) | 32'd1;
                window_nxt     = (in_rx_ack < 32'(WINDOW)) ? in_rx_ack[5:0]
                                                           : 6'(WINDOW);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (!slot_valid_r[cnt_slot]) begin
          slot_valid_nxt[cnt_slot] = 1'b1;
          ram_wr_en     = 1'b1;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = 5'(cnt_slot);
        end else if (cnt_r == SLOTS_C - CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_WALK: begin
        if (cnt_r < WALK_C) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r < SLOTS_C) begin
            ram_rd_en    = 1'b1;
            pipe_vld_nxt = slot_valid_r[cnt_slot];
            pipe_idx_nxt = cnt_slot;
          end
          // drop count: one bit of the partner window per cycle
          if ((cnt_r < WINDOW_C) && (cnt_r < CNT_W'(window_r)) && !rbits_r[cnt_r[4:0]]) begin
            dropped_nxt = dropped_r + 6'd1;
          end
        end
        if (pipe_vld_r) begin
          if (too_old) begin
            next_seq_nxt  = next_seq_r + 32'd1;
            ram_wr_en     = 1'b1;
            ram_wr_addr   = pipe_idx_r;
            ram_wr_data   = next_seq_r + 32'd1;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_RESEND;
            out_seq_nxt   = next_seq_r + 32'd1;
            out_slot_nxt  = 5'(pipe_idx_r);
            out_last_nxt  = 1'b0;
          end else if (acked) begin
            slot_valid_nxt[pipe_idx_r] = 1'b0;
          end
        end else if (cnt_r == WALK_C) begin
          local_seq_nxt = next_seq_r;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RX_DONE;
          out_seq_nxt   = next_seq_r;
          out_drop_nxt  = dropped_r;
          out_win_nxt   = window_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      local_seq_r  <= 32'd0;
      remote_seq_r <= 32'd0;
      ack_bits_r   <= 32'd0;
      slot_valid_r <= '0;
      cnt_r        <= '0;
      pipe_vld_r   <= 1'b0;
      dropped_r    <= 6'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      local_seq_r  <= local_seq_nxt;
      remote_seq_r <= remote_seq_nxt;
      ack_bits_r   <= ack_bits_nxt;
      slot_valid_r <= slot_valid_nxt;
      cnt_r        <= cnt_nxt;
      pipe_vld_r   <= pipe_vld_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r <= pipe_idx_nxt;
    next_seq_r <= next_seq_nxt;
    rack_r     <= rack_nxt;
    rbits_r    <= rbits_nxt;
    window_r   <= window_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_ack_r  <= out_ack_nxt;
    out_bits_r <= out_bits_nxt;
    out_slot_r <= out_slot_nxt;
    out_full_r <= out_full_nxt;
    out_drop_r <= out_drop_nxt;
    out_win_r  <= out_win_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_sequence      = out_seq_r;
  assign out_ack           = out_ack_r;
  assign out_ack_bits      = out_bits_r;
  assign out_slot_index    = out_slot_r;
  assign out_history_full  = out_full_r;
  assign out_dropped_count = out_drop_r;
  assign out_window_count  = out_win_r;
  assign out_last          = out_last_r;

endmodule
`default_nettype wire
